// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every rising edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/rpbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rpbe_pkg
// types, codes and helpers for the rgb pixel buffer engine
// ----------------------------------------------------------------------------
package rpbe_pkg;

    // default store size
    localparam int DEF_COLS   = 8;
    localparam int DEF_ROWS   = 8;
    // longest burst of result items for one request
    localparam int RESULT_CAP = 64;
    // coordinates on the ports are three bits, so at most eight are reachable
    localparam int COORD_W    = 3;
    localparam int COORD_SPAN = 8;
    // word address is four times a pixel number, low six bits of that number
    localparam int LIN_W      = 6;
    localparam logic [7:0] CH_MAX = 8'd255;

    typedef enum logic [2:0] {
        REQ_SET_RGB   = 3'd0,
        REQ_SET_NAMED = 3'd1,
        REQ_INCREASE  = 3'd2,
        REQ_DECREASE  = 3'd3,
        REQ_COPY      = 3'd4,
        REQ_READ      = 3'd5,
        REQ_EMIT_ONE  = 3'd6,
        REQ_EMIT_ALL  = 3'd7
    } req_code_t;

    typedef enum logic [2:0] {
        COL_RED    = 3'd0,
        COL_YELLOW = 3'd1,
        COL_PURPLE = 3'd2,
        COL_GREEN  = 3'd3,
        COL_BLUE   = 3'd4,
        COL_TEAL   = 3'd5,
        COL_WHITE  = 3'd6,
        COL_OFF    = 3'd7
    } colour_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_ALU,
        ST_RESP,
        ST_SCAN_RD,
        ST_SCAN_OUT
    } state_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] pos_x;
        logic [2:0] pos_y;
        logic [2:0] src_x;
        logic [2:0] src_y;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [2:0] color_name;
    } rpbe_in_t;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        lit;
        logic        word_valid;
        logic [23:0] device_word;
        logic [7:0]  word_addr;
        logic        last;
    } rpbe_out_t;

    // packed rgb for a colour code, black for off
    function automatic logic [23:0] named_colour(input logic [2:0] code);
        logic [23:0] c;
        unique case (code)
            COL_RED:    c = {CH_MAX, 8'd0,   8'd0};
            COL_YELLOW: c = {CH_MAX, CH_MAX, 8'd0};
            COL_PURPLE: c = {CH_MAX, 8'd0,   CH_MAX};
            COL_GREEN:  c = {8'd0,   CH_MAX, 8'd0};
            COL_BLUE:   c = {8'd0,   8'd0,   CH_MAX};
            COL_TEAL:   c = {8'd0,   CH_MAX, CH_MAX};
            COL_WHITE:  c = {CH_MAX, CH_MAX, CH_MAX};
            default:    c = 24'd0;
        endcase
        return c;
    endfunction

    // fold a three-bit coordinate into 0..span-1 by up to three subtractions of span; a span of one is not fully folded
    function automatic logic [2:0] wrap_coord(input logic [2:0] v, input int span);
        logic [2:0] r;
        int         i;
        r = v;
        for (i = 0; i < 3; i++) begin
            if (32'(r) >= span) begin
                r = r - 3'(span);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rgb_pixel_buffer_engine_top.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_buffer_engine_top
// pixel store with set, adjust, copy, read and emit requests
// ----------------------------------------------------------------------------
//  channel | ports                     | direction | payload
//  request | s_valid s_ready s_item    | in        | rpbe_in_t
//  result  | m_valid m_ready m_item    | out       | rpbe_out_t
//
//  set, copy, read and emit one: fetch, load and result states per request
//  increase and decrease: adder state too, one channel per cycle through the
//  shared saturating adder
//  emit all: store read, then output load, for each pixel, one result each
//  reset clears the store at once through per-entry valid bits
//  a stalled result holds only its own register; a new request is taken
//  once the previous one has loaded it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_pixel_buffer_engine_top #(
    parameter int COLS = rpbe_pkg::DEF_COLS,
    parameter int ROWS = rpbe_pkg::DEF_ROWS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rpbe_pkg::rpbe_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rpbe_pkg::rpbe_out_t m_item
);
    import rpbe_pkg::*;

    // reachable part of the store
    localparam int XS    = (COLS < COORD_SPAN) ? COLS : COORD_SPAN;
    localparam int YS    = (ROWS < COORD_SPAN) ? ROWS : COORD_SPAN;
    localparam int DEPTH = XS * YS;
    localparam int IW    = $clog2(DEPTH);
    localparam int NPIX  = COLS * ROWS;
    localparam int TOTAL = (NPIX < RESULT_CAP) ? NPIX : RESULT_CAP;
    localparam int NW    = $clog2(TOTAL);
    localparam int CXW   = $clog2(COLS);
    localparam int RYW   = $clog2(ROWS);

    // control and payload registers
    state_t            state_reg, state_next;
    rpbe_in_t          req_reg, req_next;
    logic [IW-1:0]     tgt_idx_reg, tgt_idx_next;
    logic [IW-1:0]     src_idx_reg, src_idx_next;
    logic [7:0]        tgt_addr_reg, tgt_addr_next;
    logic [23:0]       pix_reg, pix_next;
    logic [23:0]       opnd_reg, opnd_next;
    logic [1:0]        ch_cnt_reg, ch_cnt_next;
    logic [CXW-1:0]    scan_x_reg, scan_x_next;
    logic [RYW-1:0]    scan_y_reg, scan_y_next;
    logic [NW-1:0]     scan_n_reg, scan_n_next;
    logic              out_valid_reg, out_valid_next;
    rpbe_out_t         out_item_reg, out_item_next;
    logic [DEPTH-1:0]  valid_reg;

    // store and its read port
    logic [23:0]       mem [DEPTH];
    logic [23:0]       rd_data_reg;
    logic              rd_ok_reg;
    logic [IW-1:0]     rd_idx;
    logic              rd_inb;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;

    // decoded coordinates
    logic [2:0]        tgt_px, tgt_py, src_px, src_py;
    logic [LIN_W-1:0]  tgt_lin;
    logic [LIN_W-1:0]  scan_lin;
    logic [IW-1:0]     scan_idx;
    logic              scan_inb;
    logic              scan_last;
    logic [23:0]       cur_pix;
    logic              out_free;
    logic              out_load;

    // shared saturating add / subtract unit, works on the top byte
    logic              alu_sub;
    logic [7:0]        alu_a, alu_b, alu_res;
    logic [8:0]        alu_sum;

    assign alu_sub = (req_reg.req_type == REQ_DECREASE);
    assign alu_a   = pix_reg[23:16];
    assign alu_b   = alu_sub ? ~opnd_reg[23:16] : opnd_reg[23:16];
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {8'd0, alu_sub};

    always_comb begin
        if (alu_sub) begin
            alu_res = alu_sum[8] ? alu_sum[7:0] : 8'd0;
        end else begin
            alu_res = alu_sum[8] ? CH_MAX : alu_sum[7:0];
        end
    end

    // coordinate folding for the incoming request
    assign tgt_px  = wrap_coord(s_item.pos_x, COLS);
    assign tgt_py  = wrap_coord(s_item.pos_y, ROWS);
    assign src_px  = wrap_coord(s_item.src_x, COLS);
    assign src_py  = wrap_coord(s_item.src_y, ROWS);
    assign tgt_lin = LIN_W'(tgt_px) + LIN_W'(tgt_py) * LIN_W'(COLS);

    // scan position for emit all
    assign scan_lin  = LIN_W'(scan_x_reg) + LIN_W'(scan_y_reg) * LIN_W'(COLS);
    assign scan_inb  = (32'(scan_x_reg) < XS) && (32'(scan_y_reg) < YS);
    assign scan_idx  = IW'(3'(scan_x_reg)) + IW'(3'(scan_y_reg)) * IW'(XS);
    assign scan_last = (scan_n_reg == NW'(TOTAL - 1));

    // read data, unwritten entries read as black
    assign cur_pix  = rd_ok_reg ? rd_data_reg : 24'd0;
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // sequencer: next state, store access and result loading
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        tgt_idx_next  = tgt_idx_reg;
        src_idx_next  = src_idx_reg;
        tgt_addr_next = tgt_addr_reg;
        pix_next      = pix_reg;
        opnd_next     = opnd_reg;
        ch_cnt_next   = ch_cnt_reg;
        scan_x_next   = scan_x_reg;
        scan_y_next   = scan_y_reg;
        scan_n_next   = scan_n_reg;
        out_item_next = out_item_reg;
        out_load      = 1'b0;
        rd_idx        = tgt_idx_reg;
        rd_inb        = 1'b1;
        wr_en         = 1'b0;
        wr_idx        = tgt_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_item;
                    tgt_idx_next  = IW'(tgt_px) + IW'(tgt_py) * IW'(XS);
                    src_idx_next  = IW'(src_px) + IW'(src_py) * IW'(XS);
                    tgt_addr_next = {tgt_lin, 2'b00};
                    scan_x_next   = '0;
                    scan_y_next   = '0;
                    scan_n_next   = '0;
                    state_next    = (s_item.req_type == REQ_EMIT_ALL) ? ST_SCAN_RD
                                                                      : ST_FETCH;
                end
            end

            // copy reads its source, everything else the target
            ST_FETCH: begin
                rd_idx     = (req_reg.req_type == REQ_COPY) ? src_idx_reg : tgt_idx_reg;
                state_next = ST_LOAD;
            end

            ST_LOAD: begin
                state_next = ST_RESP;
                case (req_reg.req_type) inside
                    REQ_SET_RGB: begin
                        pix_next = {req_reg.red_in, req_reg.green_in, req_reg.blue_in};
                    end
                    REQ_SET_NAMED: begin
                        pix_next = named_colour(req_reg.color_name);
                    end
                    REQ_INCREASE, REQ_DECREASE: begin
                        pix_next    = cur_pix;
                        opnd_next   = {req_reg.red_in, req_reg.green_in, req_reg.blue_in};
                        ch_cnt_next = 2'd0;
                        state_next  = ST_ALU;
                    end
                    default: begin
                        pix_next = cur_pix;
                    end
                endcase
            end

            // one channel per cycle, bytes rotate back into place after three
            ST_ALU: begin
                pix_next    = {pix_reg[15:0], alu_res};
                opnd_next   = {opnd_reg[15:0], 8'd0};
                ch_cnt_next = ch_cnt_reg + 2'd1;
                if (ch_cnt_reg == 2'd2) begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    out_item_next.red_out     = pix_reg[23:16];
                    out_item_next.green_out   = pix_reg[15:8];
                    out_item_next.blue_out    = pix_reg[7:0];
                    out_item_next.lit         = |pix_reg;
                    out_item_next.word_valid  = 1'b0;
                    out_item_next.device_word = 24'd0;
                    out_item_next.word_addr   = 8'd0;
                    out_item_next.last        = 1'b1;
                    if (req_reg.req_type == REQ_EMIT_ONE) begin
                        out_item_next.word_valid  = 1'b1;
                        out_item_next.device_word = pix_reg;
                        out_item_next.word_addr   = tgt_addr_reg;
                    end
                    case (req_reg.req_type) inside
                        REQ_SET_RGB, REQ_SET_NAMED, REQ_INCREASE, REQ_DECREASE,
                        REQ_COPY: begin
                            wr_en = 1'b1;
                        end
                        default: begin
                            wr_en = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN_RD: begin
                rd_idx     = scan_idx;
                rd_inb     = scan_inb;
                state_next = ST_SCAN_OUT;
            end

            // column-by-column walk: y (the row) runs fastest, x steps after the last row
            ST_SCAN_OUT: begin
                // keep the read port on the scanned pixel while the result stalls
                rd_idx = scan_idx;
                rd_inb = scan_inb;
                if (out_free) begin
                    out_load                  = 1'b1;
                    out_item_next.red_out     = cur_pix[23:16];
                    out_item_next.green_out   = cur_pix[15:8];
                    out_item_next.blue_out    = cur_pix[7:0];
                    out_item_next.lit         = |cur_pix;
                    out_item_next.word_valid  = 1'b1;
                    out_item_next.device_word = cur_pix;
                    out_item_next.word_addr   = {scan_lin, 2'b00};
                    out_item_next.last        = scan_last;
                    scan_n_next               = scan_n_reg + NW'(1);
                    if (scan_y_reg == RYW'(ROWS - 1)) begin
                        scan_y_next = '0;
                        scan_x_next = scan_x_reg + CXW'(1);
                    end else begin
                        scan_y_next = scan_y_reg + RYW'(1);
                    end
                    state_next = scan_last ? ST_IDLE : ST_SCAN_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        tgt_idx_reg  <= tgt_idx_next;
        src_idx_reg  <= src_idx_next;
        tgt_addr_reg <= tgt_addr_next;
        pix_reg      <= pix_next;
        opnd_reg     <= opnd_next;
        ch_cnt_reg   <= ch_cnt_next;
        scan_x_reg   <= scan_x_next;
        scan_y_reg   <= scan_y_next;
        scan_n_reg   <= scan_n_next;
        out_item_reg <= out_item_next;
    end

    // pixel store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= pix_reg;
        end
        rd_data_reg <= mem[rd_idx];
        rd_ok_reg   <= valid_reg[rd_idx] && rd_inb;
    end

    // checks on the sequencer and the store
    `ASSERT_RST(a_accept_leaves_idle, aclk, aresetn,
        (s_valid && s_ready) |=> (state_reg == ST_FETCH || state_reg == ST_SCAN_RD),
        "accepted item did not start work")
    `ASSERT_RST(a_alu_count, aclk, aresetn,
        (state_reg == ST_ALU) |-> (ch_cnt_reg <= 2'd2),
        "channel counter ran past blue")
    `ASSERT_RST(a_write_marks_valid, aclk, aresetn,
        wr_en |=> valid_reg[$past(wr_idx)],
        "written entry not marked valid")
    `ASSERT_RST(a_single_last, aclk, aresetn,
        (state_reg == ST_RESP && out_load) |=> (m_valid && m_item.last),
        "single result item without last")
    `ASSERT_RST(a_scan_ends_idle, aclk, aresetn,
        (state_reg == ST_SCAN_OUT && out_load && scan_last) |=> (state_reg == ST_IDLE),
        "scan did not stop after its last item")

endmodule
